[rtl/core/self_organizing_list_lookup_core_defines.svh]
// Assertion macros for the self-organizing list lookup core.
`ifndef SELF_ORGANIZING_LIST_LOOKUP_CORE_DEFINES_SVH
`define SELF_ORGANIZING_LIST_LOOKUP_CORE_DEFINES_SVH

// Combinational or implication property, sampled on clk_i, off during reset.
`define SOLL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property that must hold in the cycle after the antecedent.
`define SOLL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/soll_pkg.sv]
// Shared constants and types of the self-organizing list lookup core.
package soll_pkg;

  localparam int unsigned DepthDefault = 256;
  localparam int unsigned KeyW         = 32;
  localparam int unsigned CountW       = 32;
  localparam int unsigned SlotW        = 8;
  localparam int unsigned PosW         = 8;
  localparam int unsigned ModeW        = 2;
  localparam int unsigned EntriesW     = 9;
  localparam int unsigned PaddrW       = 3;
  localparam int unsigned PdataW       = 32;

  typedef enum logic [ModeW-1:0] {
    MODE_FRONT     = 2'd0,
    MODE_TRANSPOSE = 2'd1,
    MODE_COUNT     = 2'd2
  } mode_e;

  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_LOOKUP = 1'b1
  } func_e;

  // register index as decoded from paddr[2]
  typedef enum logic {
    REG_MODE    = 1'b0,
    REG_ENTRIES = 1'b1
  } reg_e;

  typedef struct packed {
    mode_e                mode;
    logic [EntriesW-1:0]  entries;
  } cfg_t;

  // one table word: hit count above key
  typedef struct packed {
    logic [CountW-1:0] count;
    logic [KeyW-1:0]   key;
  } word_t;

endpackage

[rtl/core/soll_req_if.sv]
// Request channel: valid/ready handshake carrying one load or lookup.
interface soll_req_if;
  logic                              valid;
  logic                              ready;
  logic                              func;
  logic [soll_pkg::SlotW-1:0]        slot;
  logic signed [soll_pkg::KeyW-1:0]  key_value;

  modport source (output valid, func, slot, key_value, input ready);
  modport sink   (input valid, func, slot, key_value, output ready);
endinterface

[rtl/core/soll_rsp_if.sv]
// Response channel: valid/ready handshake carrying found flag and position.
interface soll_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [soll_pkg::PosW-1:0]   position;

  modport source (output valid, found, position, input ready);
  modport sink   (input valid, found, position, output ready);
endinterface

[rtl/core/soll_apb.sv]
// APB configuration registers: reorder mode and number of entries in use.
module soll_apb (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [soll_pkg::PaddrW-1:0]   paddr,
  input  logic [soll_pkg::PdataW-1:0]   pwdata,
  output logic [soll_pkg::PdataW-1:0]   prdata,
  output logic                          pready,
  output soll_pkg::cfg_t                cfg_o
);

  logic [soll_pkg::ModeW-1:0]    mode_q;
  logic [soll_pkg::EntriesW-1:0] entries_q;
  logic                          wr_en;
  soll_pkg::reg_e                reg_sel;

  // word-aligned decode, byte lanes ignored
  assign reg_sel = soll_pkg::reg_e'(paddr[2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= '0;
      entries_q <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        soll_pkg::REG_MODE:    mode_q    <= pwdata[soll_pkg::ModeW-1:0];
        soll_pkg::REG_ENTRIES: entries_q <= pwdata[soll_pkg::EntriesW-1:0];
        default:               mode_q    <= mode_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      soll_pkg::REG_MODE:    prdata = soll_pkg::PdataW'(mode_q);
      soll_pkg::REG_ENTRIES: prdata = soll_pkg::PdataW'(entries_q);
      default:               prdata = '0;
    endcase
  end

  assign cfg_o.mode    = soll_pkg::mode_e'(mode_q);
  assign cfg_o.entries = entries_q;

endmodule

[rtl/core/soll_ram.sv]
// Single-port table memory of key/count words with registered read data.
module soll_ram #(
  parameter int unsigned DEPTH = soll_pkg::DepthDefault,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   addr_i,
  input  soll_pkg::word_t wdata_i,
  output soll_pkg::word_t rdata_o
);

  soll_pkg::word_t mem_q [DEPTH];
  soll_pkg::word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/self_organizing_list_lookup_core.sv]
// Top level of the self-organizing list lookup core.
//
// Keeps a table of DEPTH signed 32-bit keys, each with a 32-bit saturating hit
// count, in one single-port memory (one word = count and key). A load request
// (func 0) writes the key at slot, clears its count and answers found=0,
// position=0 in the cycle after acceptance; a slot at or beyond DEPTH is dropped.
// A lookup request (func 1) scans positions 0 .. min(entries_in_use, DEPTH)-1
// through one shared 32-bit comparator, one memory word per cycle, and stops
// at the first equal key. The response carries found and the position before
// reordering (low 8 bits), or found=0/position=0 on a miss, and is posted as
// soon as the scan ends. The table then reorders per reorder_mode: 0 swaps the
// hit key with position 0, 1 swaps it with its predecessor, 2 bumps the hit
// count and swaps key and count with the predecessor if the new count is
// larger; mode 3 only reports. A load leaves the core idle; a lookup that hits
// runs the scan, a planning state, then up to two memory writes, and a miss
// returns to idle as the scan ends. Requests are taken only while no lookup is
// in progress; a pending response does not block a new request if it is taken
// in the same cycle. After reset a clearing pass zeroes the memory before the
// first request is taken; configuration writes are accepted throughout.
// Registers: 0x0 reorder_mode, 0x4 entries_in_use.
`include "self_organizing_list_lookup_core_defines.svh"

module self_organizing_list_lookup_core #(
  parameter int unsigned DEPTH = soll_pkg::DepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  soll_req_if.sink                      req_i,
  soll_rsp_if.source                    rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [soll_pkg::PaddrW-1:0]   paddr,
  input  logic [soll_pkg::PdataW-1:0]   pwdata,
  output logic [soll_pkg::PdataW-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // wide enough for entries_in_use and for DEPTH itself
  localparam int unsigned LimW = (AW + 1 > soll_pkg::EntriesW) ? AW + 1 : soll_pkg::EntriesW;

  typedef enum logic [2:0] {
    ST_CLEAR,   // post-reset memory clear, one word per cycle
    ST_IDLE,    // waiting for a request
    ST_SCAN,    // compare one word per cycle
    ST_PLAN,    // work out the reorder writes
    ST_WR_A,    // first write-back
    ST_WR_B     // second write-back of a swap
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  soll_pkg::cfg_t cfg;

  soll_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_e                       state_q;
  logic [AW-1:0]                clr_q;
  logic [AW-1:0]                cur_q;      // position whose word is on rdata
  logic [LimW-1:0]              limit_q;
  logic [soll_pkg::KeyW-1:0]    key_q;
  soll_pkg::mode_e              mode_q;     // mode latched per lookup
  soll_pkg::word_t              word0_q;    // word at position 0
  soll_pkg::word_t              prev_q;     // word at cur_q-1
  soll_pkg::word_t              hit_q;
  logic [AW-1:0]                pos_q;
  logic [AW-1:0]                wr_a_addr_q, wr_b_addr_q;
  soll_pkg::word_t              wr_a_data_q, wr_b_data_q;
  logic                         wr_b_en_q;
  logic                         out_valid_q;
  logic                         out_found_q;
  logic [soll_pkg::PosW-1:0]    out_pos_q;

  // ---------------------------------------------------------------------------
  // Memory port
  // ---------------------------------------------------------------------------
  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  soll_pkg::word_t ram_wdata;
  soll_pkg::word_t ram_rdata;

  soll_ram #(.DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  logic            in_acc;
  logic            is_load;
  logic            slot_ok;
  logic [LimW-1:0] entries_ext;
  logic [LimW-1:0] lim_new;

  assign req_i.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp_o.ready);
  assign in_acc      = req_i.valid && req_i.ready;
  assign is_load     = (req_i.func == soll_pkg::FUNC_LOAD);
  assign slot_ok     = LimW'(req_i.slot) < LimW'(DEPTH);
  assign entries_ext = LimW'(cfg.entries);
  // entries_in_use above DEPTH clips to DEPTH
  assign lim_new     = (entries_ext > LimW'(DEPTH)) ? LimW'(DEPTH) : entries_ext;

  // shared comparator of the scan
  logic scan_match;
  logic scan_last;

  assign scan_match = (ram_rdata.key == key_q);
  assign scan_last  = ((LimW'(cur_q) + LimW'(1)) == limit_q);

  // ---------------------------------------------------------------------------
  // Reorder planning (from registered hit, predecessor and front words)
  // ---------------------------------------------------------------------------
  logic                        pos_nz;
  logic [soll_pkg::CountW-1:0] cnt_inc;
  logic                        plan_a, plan_b;
  logic [AW-1:0]               plan_a_addr, plan_b_addr;
  soll_pkg::word_t             plan_a_data, plan_b_data;

  assign pos_nz  = (pos_q != '0);
  assign cnt_inc = (hit_q.count == '1) ? hit_q.count : hit_q.count + soll_pkg::CountW'(1);

  always_comb begin
    plan_a      = 1'b0;
    plan_b      = 1'b0;
    plan_a_addr = pos_q;
    plan_b_addr = pos_q - AW'(1);
    plan_a_data = hit_q;
    plan_b_data = prev_q;
    unique case (mode_q)
      soll_pkg::MODE_FRONT: begin
        if (pos_nz) begin
          plan_a          = 1'b1;
          plan_b          = 1'b1;
          plan_a_data.key = word0_q.key;
          plan_b_addr     = '0;
          plan_b_data     = word0_q;
          plan_b_data.key = hit_q.key;
        end
      end
      soll_pkg::MODE_TRANSPOSE: begin
        if (pos_nz) begin
          plan_a          = 1'b1;
          plan_b          = 1'b1;
          plan_a_data.key = prev_q.key;
          plan_b_data.key = hit_q.key;
        end
      end
      soll_pkg::MODE_COUNT: begin
        plan_a = 1'b1;
        if (pos_nz && (cnt_inc > prev_q.count)) begin
          plan_b            = 1'b1;
          plan_a_data       = prev_q;
          plan_b_data.count = cnt_inc;
          plan_b_data.key   = hit_q.key;
        end else begin
          plan_a_data.count = cnt_inc;
        end
      end
      default: begin
        // unused mode: report only
        plan_a = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Memory port mux
  // ---------------------------------------------------------------------------
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wdata = '0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
      end
      ST_IDLE: begin
        // lookup reads position 0 at acceptance
        if (in_acc && is_load && slot_ok) begin
          ram_we        = 1'b1;
          ram_addr      = AW'(req_i.slot);
          ram_wdata.key = req_i.key_value;
        end
      end
      ST_SCAN: begin
        ram_addr = cur_q + AW'(1);
      end
      ST_WR_A: begin
        ram_we    = 1'b1;
        ram_addr  = wr_a_addr_q;
        ram_wdata = wr_a_data_q;
      end
      ST_WR_B: begin
        ram_we    = 1'b1;
        ram_addr  = wr_b_addr_q;
        ram_wdata = wr_b_data_q;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cur_q       <= '0;
      limit_q     <= '0;
      key_q       <= '0;
      mode_q      <= soll_pkg::MODE_FRONT;
      word0_q     <= '0;
      prev_q      <= '0;
      hit_q       <= '0;
      pos_q       <= '0;
      wr_a_addr_q <= '0;
      wr_b_addr_q <= '0;
      wr_a_data_q <= '0;
      wr_b_data_q <= '0;
      wr_b_en_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_found_q <= 1'b0;
      out_pos_q   <= '0;
    end else begin
      // a load or an empty search posts its own response at this edge
      if (rsp_o.valid && rsp_o.ready && !(in_acc && (is_load || lim_new == '0))) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            if (is_load) begin
              out_valid_q <= 1'b1;
              out_found_q <= 1'b0;
              out_pos_q   <= '0;
            end else begin
              key_q   <= req_i.key_value;
              limit_q <= lim_new;
              mode_q  <= cfg.mode;
              cur_q   <= '0;
              if (lim_new == '0) begin
                // nothing to search
                out_valid_q <= 1'b1;
                out_found_q <= 1'b0;
                out_pos_q   <= '0;
              end else begin
                state_q <= ST_SCAN;
              end
            end
          end
        end
        ST_SCAN: begin
          if (scan_match) begin
            hit_q       <= ram_rdata;
            pos_q       <= cur_q;
            out_valid_q <= 1'b1;
            out_found_q <= 1'b1;
            out_pos_q   <= soll_pkg::PosW'(cur_q);
            state_q     <= ST_PLAN;
          end else if (scan_last) begin
            out_valid_q <= 1'b1;
            out_found_q <= 1'b0;
            out_pos_q   <= '0;
            state_q     <= ST_IDLE;
          end else begin
            prev_q <= ram_rdata;
            if (cur_q == '0) begin
              word0_q <= ram_rdata;
            end
            cur_q <= cur_q + AW'(1);
          end
        end
        ST_PLAN: begin
          wr_a_addr_q <= plan_a_addr;
          wr_a_data_q <= plan_a_data;
          wr_b_addr_q <= plan_b_addr;
          wr_b_data_q <= plan_b_data;
          wr_b_en_q   <= plan_b;
          state_q     <= plan_a ? ST_WR_A : ST_IDLE;
        end
        ST_WR_A: begin
          state_q <= wr_b_en_q ? ST_WR_B : ST_IDLE;
        end
        ST_WR_B: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.found    = out_found_q;
  assign rsp_o.position = out_pos_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SOLL_ASSERT(a_scan_in_range,
               (state_q == ST_SCAN) |-> (LimW'(cur_q) < limit_q), "scan past limit")
  `SOLL_ASSERT(a_scan_no_write,
               (state_q == ST_SCAN) |-> !ram_we, "memory write during scan")
  `SOLL_ASSERT(a_miss_pos_zero,
               (rsp_o.valid && !rsp_o.found) |-> (rsp_o.position == '0), "miss with position")
  `SOLL_ASSERT_NEXT(a_load_answers, (in_acc && is_load), rsp_o.valid, "load without response")

endmodule

[test/tb.sv]
// Self-checking testbench for the self-organizing list lookup core.
`timescale 1ns / 1ps

module tb;
  import soll_pkg::*;

  // Table size of the instance (default parameter) and run shaping.
  localparam int unsigned TableDepth    = DepthDefault;
  localparam int unsigned ItemTarget    = 1550;
  // After the last answer the core may still plan and do two write-backs,
  // so the drain waits SettleCycles on top to let them finish.
  localparam int unsigned SettleCycles  = 8;
  // Longest quiet stretch: clearing pass, full scan, stalls, and a
  // register update between phases, taken several times over.
  localparam int unsigned WatchdogLimit = 4000;
  localparam logic [1:0]  MODE_REPORT_ONLY = 2'd3;

  typedef struct {
    func_e             func;
    logic [SlotW-1:0]  slot;
    logic [KeyW-1:0]   key;
    int unsigned       gap;
  } req_item_t;

  typedef struct {
    logic            found;
    logic [PosW-1:0] position;
  } answer_t;

  logic clk_i;
  logic rst_ni;

  // APB-style register port
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  soll_req_if req_if ();
  soll_rsp_if rsp_if ();

  self_organizing_list_lookup_core u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the table: keys, hit counts and the two registers. Updated when
  // a request is taken, so each answer is predicted in acceptance order.
  // ---------------------------------------------------------------------------
  logic [KeyW-1:0]     keys [TableDepth];
  logic [CountW-1:0]   hits [TableDepth];
  logic [1:0]          cur_mode;
  logic [EntriesW-1:0] cur_entries;

  // Slots loaded so far (stimulus side): lookups never scan an unloaded slot.
  bit written [TableDepth];

  req_item_t   request_q [$];
  answer_t     answer_q  [$];
  int unsigned issued;
  int unsigned taken;
  int unsigned err_cnt;
  bit          calm;      // phase without idling on either side
  bit          req_fire;  // handshakes seen at the last rising edge
  bit          rsp_fire;

  // Applies one request to the shadow table and returns the expected answer.
  function automatic answer_t table_access(input req_item_t it);
    answer_t         a;
    int unsigned     lim;
    int unsigned     p;
    logic [KeyW-1:0] tk;
    logic [CountW-1:0] tc;
    a.found    = 1'b0;
    a.position = '0;
    if (it.func == FUNC_LOAD) begin
      keys[it.slot] = it.key;
      hits[it.slot] = '0;
      return a;
    end
    lim = (cur_entries > TableDepth) ? TableDepth : cur_entries;
    for (p = 0; p < lim; p++) begin
      if (keys[p] == it.key) begin
        a.found = 1'b1;
        break;
      end
    end
    if (!a.found) return a;
    a.position = p[PosW-1:0];
    case (cur_mode)
      MODE_FRONT: begin
        if (p != 0) begin
          tk = keys[p]; keys[p] = keys[0]; keys[0] = tk;
        end
      end
      MODE_TRANSPOSE: begin
        if (p != 0) begin
          tk = keys[p]; keys[p] = keys[p-1]; keys[p-1] = tk;
        end
      end
      MODE_COUNT: begin
        // count sticks at all-ones; the front entry counts but never moves
        if (hits[p] != '1) hits[p] = hits[p] + 1'b1;
        if (p != 0 && hits[p] > hits[p-1]) begin
          tk = keys[p]; keys[p] = keys[p-1]; keys[p-1] = tk;
          tc = hits[p]; hits[p] = hits[p-1]; hits[p-1] = tc;
        end
      end
      default: ;  // unused mode: report only, no reorder
    endcase
    return a;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: rising edge. Predicts on each taken request, checks each taken
  // response against the oldest expectation, and runs the watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    req_item_t   it;
    answer_t     want;
    int unsigned quiet;
    req_fire = 1'b0;
    rsp_fire = 1'b0;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        it.func = func_e'(req_if.func);
        it.slot = req_if.slot;
        it.key  = req_if.key_value;
        it.gap  = 0;
        answer_q.push_back(table_access(it));
        taken++;
        req_fire = 1'b1;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        rsp_fire = 1'b1;
        if (answer_q.size() == 0) begin
          report_mismatch("response with no request outstanding");
        end else begin
          want = answer_q.pop_front();
          if (rsp_if.found !== want.found)
            report_mismatch($sformatf("found %b, expected %b", rsp_if.found, want.found));
          if (rsp_if.position !== want.position)
            report_mismatch($sformatf("position %0d, expected %0d",
                                      rsp_if.position, want.position));
        end
      end
      if (req_fire || rsp_fire) quiet = 0;
      else quiet++;
      if (quiet >= WatchdogLimit) begin
        $display("self_organizing_list_lookup_core verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver: falling edge. Holds an item until taken, then waits the
  // next item's gap before presenting it; gap 0 keeps valid high.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : req_driver
    req_item_t   cur;
    int unsigned gap_cnt;
    if (rst_ni && !(req_if.valid && !req_fire)) begin
      if (request_q.size() == 0) begin
        req_if.valid <= 1'b0;
      end else if (gap_cnt < request_q[0].gap) begin
        req_if.valid <= 1'b0;
        gap_cnt++;
      end else begin
        cur = request_q.pop_front();
        req_if.func      <= cur.func;
        req_if.slot      <= cur.slot;
        req_if.key_value <= cur.key;
        req_if.valid     <= 1'b1;
        gap_cnt = 0;
      end
    end
  end

  // Response side: outside calm phases, after each taken response, drop ready for a random stall.
  always @(negedge clk_i) begin : rsp_driver
    int unsigned n;
    int unsigned hold;
    if (rst_ni) begin
      n = rsp_fire ? (calm ? 0 : $urandom_range(0, 14)) : hold;
      if (n > 0) begin
        rsp_if.ready <= 1'b0;
        hold = n - 1;
      end else begin
        rsp_if.ready <= 1'b1;
        hold = 0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send(input func_e f, input logic [SlotW-1:0] s, input logic [KeyW-1:0] k);
    req_item_t it;
    it.func = f;
    it.slot = s;
    it.key  = k;
    it.gap  = calm ? 0 : $urandom_range(0, 14);
    while (request_q.size() >= 2) @(negedge clk_i);
    request_q.push_back(it);
    issued++;
    if (f == FUNC_LOAD) written[s] = 1'b1;
  endtask

  // Drain: every request taken and answered, then let the write-back finish.
  task automatic wait_idle();
    while (taken != issued || answer_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Register write (setup + access), then read back and compare.
  // Upper bits of the write data carry junk that the register must drop.
  task automatic set_reg(input reg_e r, input logic [PdataW-1:0] val);
    logic [PdataW-1:0] mask;
    logic [PdataW-1:0] data;
    mask = (r == REG_MODE) ? 32'h0000_0003 : 32'h0000_01FF;
    data = ($urandom & ~mask) | (val & mask);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (r == REG_MODE) cur_mode = data[1:0];
    else cur_entries = data[EntriesW-1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== (data & mask))
      report_mismatch($sformatf("register %s reads %h, expected %h",
                                r.name(), prdata, data & mask));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Extremes, a small pool that makes duplicate keys likely, or random.
  function automatic logic [KeyW-1:0] pick_key();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4, 5, 6: return 32'hC0DE_0000 | $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned         phase;
    int unsigned         n;
    int unsigned         i;
    int unsigned         lim;
    int unsigned         holes;
    int unsigned         r;
    int                  hole;
    logic [EntriesW-1:0] ent;
    logic [KeyW-1:0]     k;

    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.func      = FUNC_LOAD;
    req_if.slot      = '0;
    req_if.key_value = '0;
    rsp_if.ready     = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    calm             = 1'b0;
    for (i = 0; i < TableDepth; i++) begin
      keys[i]    = '0;
      hits[i]    = '0;
      written[i] = 1'b0;
    end
    cur_mode    = MODE_FRONT;
    cur_entries = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // --- directed: zero entries, key extremes, duplicates, last slot --------
    set_reg(REG_MODE, PdataW'(MODE_FRONT));
    set_reg(REG_ENTRIES, 0);
    send(FUNC_LOOKUP, 8'hFF, 32'h0000_0000);   // empty search space: miss
    send(FUNC_LOAD, 8'd0, 32'h8000_0000);
    send(FUNC_LOAD, 8'd1, 32'h7FFF_FFFF);
    send(FUNC_LOAD, 8'd2, 32'h0000_0000);
    send(FUNC_LOAD, 8'd3, 32'hFFFF_FFFF);
    send(FUNC_LOAD, 8'd4, 32'h7FFF_FFFF);      // duplicate: first match wins
    send(FUNC_LOAD, 8'd255, 32'h5A5A_5A5A);    // outside the searched range
    wait_idle();

    // move to front: hit at front, hit further in, miss beyond the range
    set_reg(REG_ENTRIES, 5);
    send(FUNC_LOOKUP, 8'h00, 32'h8000_0000);
    send(FUNC_LOOKUP, 8'h00, 32'hFFFF_FFFF);
    send(FUNC_LOOKUP, 8'h00, 32'h7FFF_FFFF);
    send(FUNC_LOOKUP, 8'h00, 32'h5A5A_5A5A);
    send(FUNC_LOOKUP, 8'h00, 32'h1357_9BDF);
    wait_idle();

    // transpose: one entry walks forward step by step
    set_reg(REG_MODE, PdataW'(MODE_TRANSPOSE));
    send(FUNC_LOOKUP, 8'h00, 32'h8000_0000);
    send(FUNC_LOOKUP, 8'h00, 32'h8000_0000);
    send(FUNC_LOOKUP, 8'h00, 32'h8000_0000);
    wait_idle();

    // count-based: repeated hits, front entry counts, a reload clears a count
    set_reg(REG_MODE, PdataW'(MODE_COUNT));
    send(FUNC_LOOKUP, 8'h00, 32'h0000_0000);
    send(FUNC_LOOKUP, 8'h00, 32'h0000_0000);
    send(FUNC_LOOKUP, 8'h00, 32'h0000_0000);
    send(FUNC_LOAD, 8'd1, 32'h0000_0000);
    send(FUNC_LOOKUP, 8'h00, 32'h0000_0000);
    wait_idle();

    // unused mode: answers but never reorders
    set_reg(REG_MODE, PdataW'(MODE_REPORT_ONLY));
    send(FUNC_LOOKUP, 8'h00, 32'hFFFF_FFFF);
    send(FUNC_LOOKUP, 8'h00, 32'hFFFF_FFFF);
    wait_idle();

    // --- random phases ---------------------------------------------------
    // Mode rotates with the phase. Most phases search a short prefix; a few
    // search the full table or ask for more than it holds (255/256/300/511).
    // Count saturation needs 2^32-1 hits and is out of reach here.
    for (phase = 0; issued < ItemTarget; phase++) begin
      wait_idle();
      calm = ($urandom_range(0, 3) == 0);
      if (phase == 2) ent = 9'd256;
      else if (phase == 5) ent = 9'd300;
      else if (phase == 8) ent = 9'd511;
      else if (phase == 11) ent = 9'd255;
      else if ($urandom_range(0, 9) == 0) ent = 9'd0;
      else ent = 9'($urandom_range(1, 24));
      set_reg(REG_MODE, 32'(phase % 4));
      set_reg(REG_ENTRIES, 32'(ent));
      lim = (ent > TableDepth) ? TableDepth : ent;
      holes = 0;
      for (i = 0; i < lim; i++) if (!written[i]) holes++;
      if (ent == 0) n = 20;
      else if (lim > 24) n = holes + 40;
      else n = $urandom_range(50, 110);

      for (i = 0; i < n; i++) begin
        hole = -1;
        for (r = 0; r < lim; r++) begin
          if (!written[r]) begin
            hole = r;
            break;
          end
        end
        if ($urandom_range(0, 99) < 60) begin
          if (hole >= 0) begin
            // fill the searched prefix before any lookup may scan it
            send(FUNC_LOAD, 8'(hole), pick_key());
          end else begin
            r = $urandom_range(0, 9);
            if (lim != 0 && r < 7) k = keys[$urandom_range(0, lim - 1)];
            else if (lim != 0 && r == 7) k = keys[lim - 1];
            else if (r == 8) k = keys[$urandom_range(0, TableDepth - 1)];
            else k = pick_key();
            send(FUNC_LOOKUP, 8'($urandom), k);
          end
        end else begin
          if (lim != 0 && $urandom_range(0, 3) != 0)
            send(FUNC_LOAD, 8'($urandom_range(0, lim - 1)), pick_key());
          else
            send(FUNC_LOAD, 8'($urandom_range(0, TableDepth - 1)), pick_key());
        end
      end
    end

    wait_idle();
    if (err_cnt == 0) begin
      $display("self_organizing_list_lookup_core verification clean");
    end else begin
      $display("self_organizing_list_lookup_core verification failed");
    end
    $finish;
  end

endmodule
